@@ hw/rtl/mlr_pkg.sv @@
package mlr_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int SETUP_W     = 49;
    localparam int CNT_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCENE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP0 = 3'd2;

    // midi codes
    localparam logic [7:0] SYS_STATUS  = 8'hF0;
    localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
    localparam logic [3:0] CMD_POLY_AT  = 4'd10;
    localparam logic [3:0] CMD_CC       = 4'd11;
    localparam logic [3:0] CMD_CHAN_AT  = 4'd13;
    localparam logic [7:0] CC_SUSTAIN   = 8'd64;
    localparam logic [7:0] MAX_NOTE     = 8'd127;
    localparam logic [7:0] MAX_SIZE     = 8'd3;

    // layer word bit positions
    localparam int B_EN      = 0;
    localparam int B_ANYCH   = 1;
    localparam int B_INCH    = 2;
    localparam int B_FORCE   = 6;
    localparam int B_OUTCH   = 7;
    localparam int B_LO      = 11;
    localparam int B_HI      = 18;
    localparam int B_XPOSE   = 25;
    localparam int B_NOSCENE = 33;
    localparam int B_FIXEN   = 34;
    localparam int B_FIXVAL  = 35;
    localparam int B_INVSUS  = 42;
    localparam int B_NOAT    = 43;
    localparam int B_CONSUME = 44;
    localparam int B_TARGET  = 45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic take;
        logic move;
        logic move_last;
        logic clear_hold;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic pass;
        logic consume;
        logic last_layer;
        logic hold_valid;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/midi_layer_router_top.sv @@
// Routes one short MIDI request through up to LAYERS layer setup words, one layer per clock
// while no passing layer waits for the output register, and delivers one routed copy per
// passing layer, the final copy marked by last_of_run. A request is accepted in idle, then
// walked one step per layer, then flushed to send out the held copy. A layer count of zero or
// a request of four or more bytes walks no layer, and a passing layer marked consume ends the
// walk after its own step. A passing layer that finds a copy already held waits while the
// output register is occupied, and so does the flush. in_stall stays high while a request is
// being walked. Configuration is written through cfg_write/cfg_index/cfg_data only while
// idle; the user must keep to this, the block itself does not enforce it.
module midi_layer_router_top #(
    parameter int LAYERS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlr_pkg::SETUP_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   event_time,
    input  logic [7:0]                    event_size,
    input  logic [7:0]                    status_byte,
    input  logic [7:0]                    first_data,
    input  logic [7:0]                    second_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    target_instrument,
    output logic [31:0]                   out_time,
    output logic [1:0]                    out_size,
    output logic [7:0]                    out_status,
    output logic [7:0]                    out_first,
    output logic [7:0]                    out_second,
    output logic                          last_of_run
);

    mlr_pkg::cmd_t    cmd;
    mlr_pkg::status_t st;

    mlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    mlr_datapath #(
        .LAYERS (LAYERS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .event_time        (event_time),
        .event_size        (event_size),
        .status_byte       (status_byte),
        .first_data        (first_data),
        .second_data       (second_data),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .target_instrument (target_instrument),
        .out_time          (out_time),
        .out_size          (out_size),
        .out_status        (out_status),
        .out_first         (out_first),
        .out_second        (out_second),
        .last_of_run       (last_of_run),
        .cmd               (cmd),
        .st                (st)
    );

    // a copy only moves into a free output register
    assert property (@(posedge clk) disable iff (!rst_n) cmd.move |-> st.out_free)
        else $error("copy moved into an occupied output register");

    // replacing the held copy must push the old one out
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && st.hold_valid) |-> cmd.move)
        else $error("held copy overwritten");

    // an accepted request blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted during walk");

    // nothing is captured while a walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> !st.hold_valid)
        else $error("request captured with a copy still held");

endmodule

@@ hw/rtl/mlr_ctrl.sv @@
module mlr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mlr_pkg::status_t st,
    output mlr_pkg::cmd_t    cmd
);

    mlr_pkg::state_t state_reg;
    mlr_pkg::state_t state_next;

    // a passing layer with a copy already held needs the output register
    logic walk_go;
    assign walk_go = !(st.pass && st.hold_valid && !st.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mlr_pkg::ST_WALK;
                end
            end
            mlr_pkg::ST_WALK:
            begin
                if (st.skip)
                begin
                    state_next = mlr_pkg::ST_FLUSH;
                end
                else if (walk_go && ((st.pass && st.consume) || st.last_layer))
                begin
                    state_next = mlr_pkg::ST_FLUSH;
                end
            end
            mlr_pkg::ST_FLUSH:
            begin
                if (!st.hold_valid || st.out_free)
                begin
                    state_next = mlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            mlr_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            mlr_pkg::ST_WALK:
            begin
                if (!st.skip && walk_go)
                begin
                    cmd.step = 1'b1;
                    cmd.take = st.pass;
                    cmd.move = st.pass && st.hold_valid;
                end
            end
            mlr_pkg::ST_FLUSH:
            begin
                if (st.hold_valid && st.out_free)
                begin
                    cmd.move       = 1'b1;
                    cmd.move_last  = 1'b1;
                    cmd.clear_hold = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/mlr_datapath.sv @@
module mlr_datapath #(
    parameter int LAYERS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mlr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlr_pkg::SETUP_W-1:0]         cfg_data,
    input  logic [31:0]                         event_time,
    input  logic [7:0]                          event_size,
    input  logic [7:0]                          status_byte,
    input  logic [7:0]                          first_data,
    input  logic [7:0]                          second_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [3:0]                          target_instrument,
    output logic [31:0]                         out_time,
    output logic [1:0]                          out_size,
    output logic [7:0]                          out_status,
    output logic [7:0]                          out_first,
    output logic [7:0]                          out_second,
    output logic                                last_of_run,
    input  mlr_pkg::cmd_t                       cmd,
    output mlr_pkg::status_t                    st
);

    localparam int IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [mlr_pkg::CNT_W-1:0] LAYERS_L = mlr_pkg::CNT_W'(LAYERS);

    // configuration
    logic signed [7:0]                 scene_reg;
    logic [mlr_pkg::CNT_W-1:0]         count_reg;
    logic [mlr_pkg::SETUP_W-1:0]       setup_reg [LAYERS];
    logic [mlr_pkg::CFG_IDX_W-1:0]     setup_sel;

    assign setup_sel = cfg_index - mlr_pkg::REG_SETUP0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scene_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < LAYERS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == mlr_pkg::REG_SCENE)
            begin
                scene_reg <= $signed(cfg_data[7:0]);
            end
            else if (cfg_index == mlr_pkg::REG_COUNT)
            begin
                count_reg <= cfg_data[mlr_pkg::CNT_W-1:0];
            end
            else if (cfg_index >= mlr_pkg::REG_SETUP0 && 32'(setup_sel) < LAYERS)
            begin
                setup_reg[IW'(setup_sel)] <= cfg_data;
            end
        end
    end

    // latched request, data bytes beyond the size read as zero
    logic [31:0] time_reg, time_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  d0_reg, d0_next;
    logic [7:0]  d1_reg, d1_next;
    logic [7:0]  d2_reg, d2_next;
    logic [IW-1:0] idx_reg, idx_next;

    always_comb
    begin
        time_next = time_reg;
        size_next = size_reg;
        d0_next   = d0_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        if (cmd.load_in)
        begin
            time_next = event_time;
            size_next = event_size;
            d0_next   = (event_size >= 8'd1) ? status_byte : 8'd0;
            d1_next   = (event_size >= 8'd2) ? first_data : 8'd0;
            d2_next   = (event_size >= 8'd3) ? second_data : 8'd0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_in)
        begin
            idx_next = '0;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        size_reg <= size_next;
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // layer evaluation
    logic [mlr_pkg::SETUP_W-1:0] w;
    logic [mlr_pkg::CNT_W-1:0]   n_eff;
    logic [3:0]                  cmd_code;
    logic                        is_sys;
    logic                        chan_ok;
    logic                        note_cmd;
    logic                        at_drop;
    logic                        range_ok;
    logic signed [8:0]           xpose;
    logic signed [9:0]           note;
    logic                        note_ok;
    logic [7:0]                  c_status;
    logic [7:0]                  c_first;
    logic [7:0]                  c_second;

    assign w        = setup_reg[idx_reg];
    assign n_eff    = (count_reg > LAYERS_L) ? LAYERS_L : count_reg;
    assign cmd_code = d0_reg[7:4];
    assign is_sys   = d0_reg >= mlr_pkg::SYS_STATUS;
    assign chan_ok  = w[mlr_pkg::B_ANYCH] || (w[mlr_pkg::B_INCH +: 4] == d0_reg[3:0]);
    assign note_cmd = (cmd_code >= mlr_pkg::CMD_NOTE_OFF) && (cmd_code <= mlr_pkg::CMD_POLY_AT);
    assign at_drop  = w[mlr_pkg::B_NOAT] &&
                      (cmd_code == mlr_pkg::CMD_POLY_AT || cmd_code == mlr_pkg::CMD_CHAN_AT);
    assign range_ok = (d1_reg >= {1'b0, w[mlr_pkg::B_LO +: 7]}) &&
                      (d1_reg <= {1'b0, w[mlr_pkg::B_HI +: 7]});
    assign xpose    = 9'($signed(w[mlr_pkg::B_XPOSE +: 8])) +
                      (w[mlr_pkg::B_NOSCENE] ? 9'sd0 : 9'(scene_reg));
    assign note     = $signed({2'b00, d1_reg}) + 10'(xpose);
    assign note_ok  = (xpose == 9'sd0) ||
                      (note >= 10'sd0 && note <= $signed({2'b00, mlr_pkg::MAX_NOTE}));

    always_comb
    begin
        c_status = d0_reg;
        c_first  = d1_reg;
        c_second = d2_reg;
        if (!is_sys)
        begin
            if (w[mlr_pkg::B_FORCE])
            begin
                c_status = {d0_reg[7:4], w[mlr_pkg::B_OUTCH +: 4]};
            end
            if (note_cmd)
            begin
                if (xpose != 9'sd0)
                begin
                    c_first = note[7:0];
                end
                if (w[mlr_pkg::B_FIXEN])
                begin
                    c_first = {1'b0, w[mlr_pkg::B_FIXVAL +: 7]};
                end
            end
            else if (cmd_code == mlr_pkg::CMD_CC && d1_reg == mlr_pkg::CC_SUSTAIN &&
                     w[mlr_pkg::B_INVSUS])
            begin
                c_second = mlr_pkg::MAX_NOTE - d2_reg;
            end
        end
        // byte positions beyond the size read back as zero
        if (size_reg < 8'd1)
        begin
            c_status = 8'd0;
        end
        if (size_reg < 8'd2)
        begin
            c_first = 8'd0;
        end
        if (size_reg < 8'd3)
        begin
            c_second = 8'd0;
        end
    end

    // one copy held back until we know whether another follows
    logic       hold_valid_reg, hold_valid_next;
    logic [3:0] h_target_reg, h_target_next;
    logic [7:0] h_status_reg, h_status_next;
    logic [7:0] h_first_reg, h_first_next;
    logic [7:0] h_second_reg, h_second_next;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        h_target_next   = h_target_reg;
        h_status_next   = h_status_reg;
        h_first_next    = h_first_reg;
        h_second_next   = h_second_reg;
        if (cmd.take)
        begin
            hold_valid_next = 1'b1;
            h_target_next   = w[mlr_pkg::B_TARGET +: 4];
            h_status_next   = c_status;
            h_first_next    = c_first;
            h_second_next   = c_second;
        end
        else if (cmd.clear_hold)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_target_reg <= h_target_next;
        h_status_reg <= h_status_next;
        h_first_reg  <= h_first_next;
        h_second_reg <= h_second_next;
    end

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  o_target_reg, o_target_next;
    logic [31:0] o_time_reg, o_time_next;
    logic [1:0]  o_size_reg, o_size_next;
    logic [7:0]  o_status_reg, o_status_next;
    logic [7:0]  o_first_reg, o_first_next;
    logic [7:0]  o_second_reg, o_second_next;
    logic        o_last_reg, o_last_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_target_next  = o_target_reg;
        o_time_next    = o_time_reg;
        o_size_next    = o_size_reg;
        o_status_next  = o_status_reg;
        o_first_next   = o_first_reg;
        o_second_next  = o_second_reg;
        o_last_next    = o_last_reg;
        if (cmd.move)
        begin
            out_valid_next = 1'b1;
            o_target_next  = h_target_reg;
            o_time_next    = time_reg;
            o_size_next    = size_reg[1:0];
            o_status_next  = h_status_reg;
            o_first_next   = h_first_reg;
            o_second_next  = h_second_reg;
            o_last_next    = cmd.move_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_target_reg <= o_target_next;
        o_time_reg   <= o_time_next;
        o_size_reg   <= o_size_next;
        o_status_reg <= o_status_next;
        o_first_reg  <= o_first_next;
        o_second_reg <= o_second_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign target_instrument = o_target_reg;
    assign out_time          = o_time_reg;
    assign out_size          = o_size_reg;
    assign out_status        = o_status_reg;
    assign out_first         = o_first_reg;
    assign out_second        = o_second_reg;
    assign last_of_run       = o_last_reg;

    // status to the controller
    assign st.skip       = (size_reg > mlr_pkg::MAX_SIZE) || (n_eff == '0);
    assign st.pass       = w[mlr_pkg::B_EN] &&
                           (is_sys || (chan_ok && !at_drop && (!note_cmd || (range_ok && note_ok))));
    assign st.consume    = w[mlr_pkg::B_CONSUME];
    assign st.last_layer = mlr_pkg::CNT_W'(idx_reg) == (n_eff - mlr_pkg::CNT_W'(1));
    assign st.hold_valid = hold_valid_reg;
    assign st.out_free   = out_free;

endmodule
